@@ hw/rtl/mvsm_pkg.sv @@
`default_nettype none

package mvsm_pkg;

    // Fixed by the stream payload widths
    localparam int VOICE_COUNT = 10;
    localparam int SAMPLE_BITS = 16;
    localparam int GAIN_W      = 16;
    localparam int LEN_W       = 17;
    localparam int TAKEN_W     = 4;

    localparam logic [1:0] MODE_WRITE  = 2'd0;
    localparam logic [1:0] MODE_START  = 2'd1;
    localparam logic [1:0] MODE_RENDER = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_VOICE,
        ST_MUL,
        ST_ACC,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic mem_rd;
        logic mul;
        logic acc;
        logic out_load;
    } t_ctrl;

endpackage

`default_nettype wire

@@ hw/rtl/multi_voice_sample_mixer_unit.sv @@
`default_nettype none

// Channel   Dir  Fields (tdata / tuser, lowest bit first)
// s_axis    in   tdata: mem_address, mem_sample, clip_base, clip_frames,
//                       clip_stereo, gain, repeat_req (82 bits, padded to 88)
//                tuser: mode
// m_axis    out  tdata: left_out, right_out, start_accepted, voice_taken,
//                       active_voices (47 bits, padded to 48)
//
// Memory writes and voice starts go from idle straight to output; a render steps
// through the voices: a read, multiply and accumulate per mono voice, two per
// stereo voice, on the one shared 16x17 multiplier and single memory read port.
// One item is in flight at a time; the next is taken once its result sits in
// the output register. A stalled output holds the block in its last step.
// Synchronous active-low reset clears all voices; sample memory is not cleared.
module multi_voice_sample_mixer_unit
    import mvsm_pkg::*;
#(
    parameter int MEM_ADDR_W = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // mem_address[15:0], mem_sample[31:16], clip_base[47:32], clip_frames[63:48],
    // clip_stereo[64], gain[80:65], repeat_req[81], zero[87:82]
    input  wire logic [87:0] s_axis_tdata,
    // mode[1:0]
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // left_out[15:0], right_out[31:16], start_accepted[32], voice_taken[36:33],
    // active_voices[46:37], zero[47]
    output logic [47:0]      m_axis_tdata
);

    localparam int MEM_DEPTH = 2 ** MEM_ADDR_W;
    localparam int SUM_W     = (MEM_ADDR_W > LEN_W + 1) ? MEM_ADDR_W : LEN_W + 1;
    localparam int VSEL_W    = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
    localparam int VIDX_W    = $clog2(VOICE_COUNT + 1);
    localparam int PROD_W    = SAMPLE_BITS + GAIN_W + 1;
    localparam int CONT_W    = PROD_W - 15;
    localparam int ACC_W     = CONT_W + 6;

    // input fields
    logic [15:0]            in_mem_address;
    logic [SAMPLE_BITS-1:0] in_mem_sample;
    logic [15:0]            in_clip_base;
    logic [15:0]            in_clip_frames;
    logic                   in_clip_stereo;
    logic [GAIN_W-1:0]      in_gain;
    logic                   in_repeat_req;
    logic [1:0]             in_mode;

    assign in_mem_address = s_axis_tdata[15:0];
    assign in_mem_sample  = s_axis_tdata[31:16];
    assign in_clip_base   = s_axis_tdata[47:32];
    assign in_clip_frames = s_axis_tdata[63:48];
    assign in_clip_stereo = s_axis_tdata[64];
    assign in_gain        = s_axis_tdata[80:65];
    assign in_repeat_req  = s_axis_tdata[81];
    assign in_mode        = s_axis_tuser;

    t_state r_state, n_state;
    t_ctrl  ctrl;

    // voice table
    logic [VOICE_COUNT-1:0] r_active;
    logic [15:0]            r_base   [VOICE_COUNT];
    logic [LEN_W-1:0]       r_len    [VOICE_COUNT];
    logic [LEN_W-1:0]       r_pos    [VOICE_COUNT];
    logic [GAIN_W-1:0]      r_gain   [VOICE_COUNT];
    logic [VOICE_COUNT-1:0] r_loop;
    logic [VOICE_COUNT-1:0] r_stereo;

    logic [VIDX_W-1:0]      r_vidx;
    logic                   r_half;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc_l;
    logic signed [ACC_W-1:0]  r_acc_r;
    logic                   r_accepted;
    logic [TAKEN_W-1:0]     r_taken;

    logic [SAMPLE_BITS-1:0] mem [MEM_DEPTH];
    logic [SAMPLE_BITS-1:0] r_mem_q;

    logic                         r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_left;
    logic signed [SAMPLE_BITS-1:0] r_out_right;
    logic                         r_out_accepted;
    logic [TAKEN_W-1:0]           r_out_taken;
    logic [VOICE_COUNT-1:0]       r_out_active;

    logic in_xfer;
    assign in_xfer = s_axis_tvalid && s_axis_tready;

    // current voice
    logic [VSEL_W-1:0] vsel;
    logic              vidx_live;
    logic              cur_active;
    logic [LEN_W-1:0]  cur_len;
    logic [LEN_W-1:0]  cur_pos;
    logic              cur_empty;
    assign vsel       = r_vidx[VSEL_W-1:0];
    assign vidx_live  = (r_vidx < VIDX_W'(VOICE_COUNT));
    assign cur_active = vidx_live && r_active[vsel];
    assign cur_len    = r_len[vsel];
    assign cur_pos    = r_pos[vsel];
    assign cur_empty  = (cur_len == '0);

    // first free slot
    logic              free_found;
    logic [VSEL_W-1:0] free_idx;
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int v = VOICE_COUNT - 1; v >= 0; v--) begin
            if (!r_active[v]) begin
                free_found = 1'b1;
                free_idx   = VSEL_W'(v);
            end
        end
    end

    // address and position step
    logic [SUM_W-1:0]      rd_sum;
    logic [SUM_W-1:0]      wr_sum;
    logic [MEM_ADDR_W-1:0] rd_addr;
    logic [MEM_ADDR_W-1:0] wr_addr;
    logic [LEN_W-1:0]      pos_inc;
    logic [LEN_W-1:0]      pos_next;
    assign rd_sum   = SUM_W'(r_base[vsel]) + SUM_W'(cur_pos);
    assign wr_sum   = SUM_W'(in_mem_address);
    assign rd_addr  = rd_sum[MEM_ADDR_W-1:0];
    assign wr_addr  = wr_sum[MEM_ADDR_W-1:0];
    assign pos_inc  = cur_pos + LEN_W'(1);
    assign pos_next = (pos_inc >= cur_len) ? '0 : pos_inc;

    // round half up then floor by 2^15
    logic signed [PROD_W-1:0] prod_rnd;
    logic signed [CONT_W-1:0] contrib;
    logic signed [ACC_W-1:0]  contrib_x;
    assign prod_rnd  = r_prod + PROD_W'(16384);
    assign contrib   = prod_rnd[PROD_W-1:15];
    assign contrib_x = ACC_W'(contrib);

    logic stereo_first;
    assign stereo_first = r_stereo[vsel] && !r_half;

    function automatic logic signed [SAMPLE_BITS-1:0] sat(input logic signed [ACC_W-1:0] x);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'((2 ** (SAMPLE_BITS - 1)) - 1);
        lo = -hi - ACC_W'(1);
        if (x > hi) begin
            sat = hi[SAMPLE_BITS-1:0];
        end else if (x < lo) begin
            sat = lo[SAMPLE_BITS-1:0];
        end else begin
            sat = x[SAMPLE_BITS-1:0];
        end
    endfunction

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_state = (in_mode == MODE_RENDER) ? ST_VOICE : ST_OUT;
                end
            end
            ST_VOICE: begin
                if (!vidx_live) begin
                    n_state = ST_OUT;
                end else if (cur_active && !cur_empty) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL:  n_state = ST_ACC;
            ST_ACC:  n_state = ST_VOICE;
            ST_OUT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        ctrl = '0;
        case (r_state)
            ST_IDLE:  ctrl.in_ready = 1'b1;
            ST_VOICE: ctrl.mem_rd   = cur_active && !cur_empty;
            ST_MUL:   ctrl.mul      = 1'b1;
            ST_ACC:   ctrl.acc      = 1'b1;
            ST_OUT:   ctrl.out_load = !r_out_valid || m_axis_tready;
            default:  ctrl = '0;
        endcase
    end

    assign s_axis_tready = ctrl.in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // sample memory
    always_ff @(posedge i_clk) begin
        if (in_xfer && in_mode == MODE_WRITE) begin
            mem[wr_addr] <= in_mem_sample;
        end
        if (ctrl.mem_rd) begin
            r_mem_q <= mem[rd_addr];
        end
    end

    // shared multiplier
    always_ff @(posedge i_clk) begin
        if (ctrl.mul) begin
            r_prod <= PROD_W'($signed(r_mem_q)) * $signed({1'b0, r_gain[vsel]});
        end
    end

    // voice table and sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= '0;
            r_vidx     <= '0;
            r_half     <= 1'b0;
            r_accepted <= 1'b0;
            r_taken    <= '0;
        end else begin
            if (in_xfer) begin
                r_vidx     <= '0;
                r_half     <= 1'b0;
                r_acc_l    <= '0;
                r_acc_r    <= '0;
                r_accepted <= 1'b0;
                r_taken    <= '0;
                if (in_mode == MODE_START && free_found) begin
                    r_active[free_idx] <= 1'b1;
                    r_base[free_idx]   <= in_clip_base;
                    r_len[free_idx]    <= in_clip_stereo ? {in_clip_frames, 1'b0}
                                                         : {1'b0, in_clip_frames};
                    r_pos[free_idx]    <= '0;
                    r_gain[free_idx]   <= in_gain;
                    r_loop[free_idx]   <= in_repeat_req;
                    r_stereo[free_idx] <= in_clip_stereo;
                    r_accepted         <= 1'b1;
                    r_taken            <= TAKEN_W'(free_idx);
                end
            end
            if (r_state == ST_VOICE && vidx_live && !ctrl.mem_rd) begin
                // idle slot, or empty clip that stops unless looped
                if (cur_active && !r_loop[vsel]) begin
                    r_active[vsel] <= 1'b0;
                end
                r_vidx <= r_vidx + VIDX_W'(1);
            end
            if (ctrl.acc) begin
                r_pos[vsel] <= pos_next;
                if (stereo_first) begin
                    r_acc_l <= r_acc_l + contrib_x;
                    r_half  <= 1'b1;
                end else begin
                    r_half <= 1'b0;
                    if (r_stereo[vsel]) begin
                        r_acc_r <= r_acc_r + contrib_x;
                    end else begin
                        r_acc_l <= r_acc_l + contrib_x;
                        r_acc_r <= r_acc_r + contrib_x;
                    end
                    if (!r_loop[vsel] && pos_next == '0) begin
                        r_active[vsel] <= 1'b0;
                    end
                    r_vidx <= r_vidx + VIDX_W'(1);
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.out_load) begin
            r_out_left     <= sat(r_acc_l);
            r_out_right    <= sat(r_acc_r);
            r_out_accepted <= r_accepted;
            r_out_taken    <= r_taken;
            r_out_active   <= r_active;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_active, r_out_taken, r_out_accepted,
                            r_out_right, r_out_left};

    a_direct_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && in_mode != MODE_RENDER) |=> (r_state == ST_OUT))
        else $error("write or start transfer did not go straight to output");

    a_vidx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vidx <= VIDX_W'(VOICE_COUNT)))
        else $error("voice index past last voice");

    a_taken_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_accepted) |-> r_out_active[r_out_taken[VSEL_W-1:0]])
        else $error("accepted start reports inactive voice");

    a_acc_only_render: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ACC) |-> $past(r_state == ST_MUL))
        else $error("accumulate without multiply");

endmodule

`default_nettype wire
